// ----- hw/rtl/vmap_pkg.sv -----
package vmap_pkg;

	localparam int ADDR_W        = 13;
	localparam int DATA_W        = 8;
	localparam int REGION_W      = 3;
	localparam int PALETTE_BYTES = 64;
	localparam int PAL_AW        = $clog2(PALETTE_BYTES);

	localparam logic              ACTION_READ  = 1'b0;
	localparam logic              ACTION_WRITE = 1'b1;

	localparam logic [REGION_W-1:0] REGION_VIDEO     = 3'd0;
	localparam logic [REGION_W-1:0] REGION_OBJECT    = 3'd1;
	localparam logic [REGION_W-1:0] REGION_BG_INDEX  = 3'd2;
	localparam logic [REGION_W-1:0] REGION_BG_DATA   = 3'd3;
	localparam logic [REGION_W-1:0] REGION_OBJ_INDEX = 3'd4;
	localparam logic [REGION_W-1:0] REGION_OBJ_DATA  = 3'd5;

	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_SCAN   = 2'd2;
	localparam logic [1:0] MODE_DRAW   = 2'd3;

	localparam logic [DATA_W-1:0] BLOCKED_DATA = 8'hFF;
	localparam logic [DATA_W-1:0] WRITE_DATA_RESULT = 8'h00;
	localparam int                INDEX_AUTO_BIT = 7;
	localparam int                INDEX_SPARE_BIT = 6;

	typedef struct packed {
		logic                action;
		logic [REGION_W-1:0] region;
		logic [ADDR_W-1:0]   address;
		logic [DATA_W-1:0]   write_data;
		logic [1:0]          ppu_mode;
		logic                bank_select;
	} request_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              granted;
	} result_t;

	typedef struct packed {
		logic                valid;
		logic                write;
		logic                granted;
		logic [REGION_W-1:0] region;
	} access_t;

	function automatic logic [DATA_W-1:0] next_index(input logic [DATA_W-1:0] idx);
		logic [PAL_AW-1:0] low;
		low = idx[PAL_AW-1:0] + PAL_AW'(1);
		if (idx[INDEX_AUTO_BIT]) begin
			next_index = {1'b1, 1'b0, low};
		end else begin
			next_index = idx;
		end
	endfunction

endpackage

// ----- hw/rtl/vmap_ram.sv -----
module vmap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                         wdata,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- hw/rtl/vmap_decode.sv -----
module vmap_decode #(
	parameter int VIDEO_BANK_BYTES = 8192,
	parameter int OBJECT_BYTES     = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  take,
	input  vmap_pkg::request_t                    request,
	input  logic                                  cfg_we,
	input  logic                                  cfg_wdata,
	output vmap_pkg::access_t                     acc_s1,
	output logic [$clog2(2*VIDEO_BANK_BYTES)-1:0] vram_addr_s1,
	output logic [$clog2(OBJECT_BYTES)-1:0]       oam_addr_s1,
	output logic [vmap_pkg::DATA_W-1:0]           wdata_s1
);

	import vmap_pkg::*;

	localparam int VRAM_AW     = $clog2(2*VIDEO_BANK_BYTES);
	localparam int OAM_AW      = $clog2(OBJECT_BYTES);
	localparam int RECIP_SHIFT = 21;
	localparam int RECIP       = (1 << RECIP_SHIFT) / OBJECT_BYTES;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int PROD_W      = ADDR_W + RECIP_W;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

	localparam logic [ADDR_W-1:0]  OBJ_SIZE = ADDR_W'(OBJECT_BYTES);
	localparam logic [ADDR_W:0]    VB_SIZE  = (ADDR_W+1)'(VIDEO_BANK_BYTES);
	localparam logic [ADDR_W+1:0]  VB_BASE  = (ADDR_W+2)'(VIDEO_BANK_BYTES);
	localparam logic [RECIP_W-1:0] RECIP_K  = RECIP_W'(RECIP);

	logic             color_q;
	logic             valid_s1;
	request_t         req_s1;
	logic [QUOT_W-1:0] quot_s1;

	logic [PROD_W-1:0] prod;
	logic [ADDR_W-1:0] obj_rem;
	logic [ADDR_W-1:0] obj_mod;
	logic [ADDR_W:0]   vid_ext;
	logic [ADDR_W:0]   vid_mod;
	logic [ADDR_W+1:0] vid_sum;
	logic              bank;
	logic              grant;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				color_q <= cfg_wdata;
			end
			valid_s1 <= take;
		end
	end

	assign prod = PROD_W'(request.address) * PROD_W'(RECIP_K);

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1  <= request;
			quot_s1 <= prod[PROD_W-1:RECIP_SHIFT];
		end
	end

	always_comb begin
		obj_rem = req_s1.address - ADDR_W'(quot_s1 * OBJECT_BYTES);
		obj_mod = (obj_rem >= OBJ_SIZE) ? obj_rem - OBJ_SIZE : obj_rem;
		vid_ext = {1'b0, req_s1.address};
		vid_mod = (vid_ext >= VB_SIZE) ? vid_ext - VB_SIZE : vid_ext;
		bank    = color_q & req_s1.bank_select;
		vid_sum = {1'b0, vid_mod} + (bank ? VB_BASE : '0);
	end

	always_comb begin
		unique case (req_s1.region)
			REGION_VIDEO:     grant = (req_s1.ppu_mode != MODE_DRAW);
			REGION_OBJECT:    grant = (req_s1.ppu_mode != MODE_SCAN) &&
			                          (req_s1.ppu_mode != MODE_DRAW);
			REGION_BG_INDEX:  grant = 1'b1;
			REGION_BG_DATA:   grant = (req_s1.ppu_mode != MODE_DRAW);
			REGION_OBJ_INDEX: grant = 1'b1;
			REGION_OBJ_DATA:  grant = (req_s1.ppu_mode != MODE_DRAW);
			default:          grant = 1'b0;
		endcase
	end

	assign acc_s1.valid   = valid_s1;
	assign acc_s1.write   = (req_s1.action == ACTION_WRITE);
	assign acc_s1.granted = grant;
	assign acc_s1.region  = req_s1.region;
	assign vram_addr_s1   = vid_sum[VRAM_AW-1:0];
	assign oam_addr_s1    = obj_mod[OAM_AW-1:0];
	assign wdata_s1       = req_s1.write_data;

	a_obj_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (obj_mod < OBJ_SIZE))
		else $error("object offset out of range");

	a_vid_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (vid_mod < VB_SIZE))
		else $error("video offset out of range");

	a_draw_blocks_video: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && req_s1.region == REGION_VIDEO && req_s1.ppu_mode == MODE_DRAW)
		|-> !grant)
		else $error("video access granted in drawing mode");

endmodule

// ----- hw/rtl/video_memory_access_port.sv -----
// Results: done strobes for each taken transaction once it has passed the s1 and s2 registers.
// Throughput: one transaction per cycle; busy stays low, each access is a single
// read or write of one memory port, and results cannot be stalled.
// Reset: arst_n clears the palette index registers, color mode and pipeline
// valid bits; memory contents are undefined until written.
module video_memory_access_port #(
	parameter int VIDEO_BANK_BYTES = 8192,
	parameter int OBJECT_BYTES     = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  vmap_pkg::request_t request,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	output logic               done,
	output vmap_pkg::result_t  result
);

	import vmap_pkg::*;

	localparam int VRAM_DEPTH = 2 * VIDEO_BANK_BYTES;
	localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
	localparam int OAM_AW     = $clog2(OBJECT_BYTES);

	access_t             acc_s1;
	logic [VRAM_AW-1:0]  vram_addr_s1;
	logic [OAM_AW-1:0]   oam_addr_s1;
	logic [DATA_W-1:0]   wdata_s1;
	logic                take;
	logic                wr_ok;

	logic [DATA_W-1:0]   bg_idx_q;
	logic [DATA_W-1:0]   obj_idx_q;

	logic                valid_s2;
	logic                write_s2;
	logic                granted_s2;
	logic [REGION_W-1:0] region_s2;
	logic [DATA_W-1:0]   idx_rd_s2;

	logic [DATA_W-1:0]   vram_rd;
	logic [DATA_W-1:0]   oam_rd;
	logic [DATA_W-1:0]   bgp_rd;
	logic [DATA_W-1:0]   obp_rd;
	logic [DATA_W-1:0]   rd_data;

	assign busy  = 1'b0;
	assign take  = start & ~busy;
	assign wr_ok = acc_s1.valid & acc_s1.write & acc_s1.granted;

	vmap_decode #(
		.VIDEO_BANK_BYTES(VIDEO_BANK_BYTES),
		.OBJECT_BYTES    (OBJECT_BYTES)
	) u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.request     (request),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.acc_s1      (acc_s1),
		.vram_addr_s1(vram_addr_s1),
		.oam_addr_s1 (oam_addr_s1),
		.wdata_s1    (wdata_s1)
	);

	vmap_ram #(.WIDTH(DATA_W), .DEPTH(VRAM_DEPTH)) u_vram (
		.clk  (clk),
		.we   (wr_ok && acc_s1.region == REGION_VIDEO),
		.addr (vram_addr_s1),
		.wdata(wdata_s1),
		.rdata(vram_rd)
	);

	vmap_ram #(.WIDTH(DATA_W), .DEPTH(OBJECT_BYTES)) u_oam (
		.clk  (clk),
		.we   (wr_ok && acc_s1.region == REGION_OBJECT),
		.addr (oam_addr_s1),
		.wdata(wdata_s1),
		.rdata(oam_rd)
	);

	vmap_ram #(.WIDTH(DATA_W), .DEPTH(PALETTE_BYTES)) u_bg_pal (
		.clk  (clk),
		.we   (wr_ok && acc_s1.region == REGION_BG_DATA),
		.addr (bg_idx_q[PAL_AW-1:0]),
		.wdata(wdata_s1),
		.rdata(bgp_rd)
	);

	vmap_ram #(.WIDTH(DATA_W), .DEPTH(PALETTE_BYTES)) u_obj_pal (
		.clk  (clk),
		.we   (wr_ok && acc_s1.region == REGION_OBJ_DATA),
		.addr (obj_idx_q[PAL_AW-1:0]),
		.wdata(wdata_s1),
		.rdata(obp_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_idx_q  <= '0;
			obj_idx_q <= '0;
			valid_s2  <= 1'b0;
		end else begin
			valid_s2 <= acc_s1.valid;
			if (wr_ok) begin
				priority case (acc_s1.region)
					REGION_BG_INDEX:  bg_idx_q  <= wdata_s1;
					REGION_BG_DATA:   bg_idx_q  <= next_index(bg_idx_q);
					REGION_OBJ_INDEX: obj_idx_q <= wdata_s1;
					REGION_OBJ_DATA:  obj_idx_q <= next_index(obj_idx_q);
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		write_s2   <= acc_s1.write;
		granted_s2 <= acc_s1.granted;
		region_s2  <= acc_s1.region;
		idx_rd_s2  <= (acc_s1.region == REGION_BG_INDEX) ? bg_idx_q : obj_idx_q;
	end

	always_comb begin
		priority if (write_s2) begin
			rd_data = WRITE_DATA_RESULT;
		end else if (!granted_s2) begin
			rd_data = BLOCKED_DATA;
		end else begin
			unique case (region_s2)
				REGION_VIDEO:     rd_data = vram_rd;
				REGION_OBJECT:    rd_data = oam_rd;
				REGION_BG_INDEX:  rd_data = idx_rd_s2;
				REGION_BG_DATA:   rd_data = bgp_rd;
				REGION_OBJ_INDEX: rd_data = idx_rd_s2;
				REGION_OBJ_DATA:  rd_data = obp_rd;
				default:          rd_data = BLOCKED_DATA;
			endcase
		end
	end

	assign done             = valid_s2;
	assign result.read_data = rd_data;
	assign result.granted   = granted_s2;

	a_done_follows_take: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, 2))
		else $error("result without a taken transaction");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(request.action, 2) == ACTION_WRITE)
		|-> result.read_data == WRITE_DATA_RESULT)
		else $error("write returned non-zero data");

	a_bg_index_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ok && acc_s1.region == REGION_BG_DATA && bg_idx_q[INDEX_AUTO_BIT])
		|=> (bg_idx_q[PAL_AW-1:0] == $past(bg_idx_q[PAL_AW-1:0]) + PAL_AW'(1)) &&
		    !bg_idx_q[INDEX_SPARE_BIT] && bg_idx_q[INDEX_AUTO_BIT])
		else $error("background palette index did not advance");

	a_obj_index_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ok && acc_s1.region == REGION_OBJ_DATA && obj_idx_q[INDEX_AUTO_BIT])
		|=> (obj_idx_q[PAL_AW-1:0] == $past(obj_idx_q[PAL_AW-1:0]) + PAL_AW'(1)) &&
		    !obj_idx_q[INDEX_SPARE_BIT] && obj_idx_q[INDEX_AUTO_BIT])
		else $error("object palette index did not advance");

endmodule
